>>> hdl/ycq_pkg.sv
// ----------------------------------------------------------------------------
// ycq_pkg
// Types, fixed-point coefficients and the rounding helper shared by the
// quadrant blackout pipeline.
// ----------------------------------------------------------------------------
package ycq_pkg;

    // pipeline depth and register widths
    localparam int NumStages  = 6;
    localparam int DimWidth   = 10;

    // largest dimension honored before halving
    localparam logic [DimWidth-1:0] MaxDimension = 10'd512;

    // configuration register indexes
    localparam logic CfgImageWidth  = 1'b0;
    localparam logic CfgImageHeight = 1'b1;

    typedef logic signed [17:0] t_coef;
    typedef logic signed [26:0] t_prod;
    typedef logic signed [27:0] t_sum;
    typedef logic [NumStages-1:0] t_stage_en;

    // forward matrix, scaled by 2^16
    localparam t_coef KyR  = 18'sd19595;
    localparam t_coef KyG  = 18'sd38470;
    localparam t_coef KyB  = 18'sd7471;
    localparam t_coef KcbR = -18'sd11056;
    localparam t_coef KcbG = -18'sd21712;
    localparam t_coef KcbB = 18'sd32768;
    localparam t_coef KcrR = 18'sd32768;
    localparam t_coef KcrG = -18'sd27440;
    localparam t_coef KcrB = -18'sd5328;
    // inverse matrix, scaled by 2^16
    localparam t_coef KrCr = 18'sd91881;
    localparam t_coef KgCb = -18'sd22551;
    localparam t_coef KgCr = -18'sd46799;
    localparam t_coef KbCb = 18'sd116130;

    localparam logic [7:0]        BlackY      = 8'd16;
    localparam logic signed [8:0] ChromaZero  = 9'sd128;
    localparam logic signed [8:0] NoOffset    = 9'sd0;

    // round to nearest, ties away from zero, add an offset and clamp to 0..255
    function automatic logic [7:0] round_clamp(input t_sum s, input logic signed [8:0] offs);
        t_sum                t;
        logic signed [11:0]  q;
        logic signed [12:0]  v;
        logic [7:0]          res;
        // floor((s + 32767) / 2^16) for negative sums matches -round(|s|)
        t = s + (s[27] ? 28'sd32767 : 28'sd32768);
        q = t[27:16];
        v = {q[11], q} + {{4{offs[8]}}, offs};
        if (v[12]) begin
            res = 8'd0;
        end else if (v > 13'sd255) begin
            res = 8'd255;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

endpackage

>>> hdl/ycbcr_quadrant_blackout.sv
// ----------------------------------------------------------------------------
// ycbcr_quadrant_blackout
// BT.601 RGB -> YCbCr -> RGB round trip with the top-right and bottom-left
// quadrants painted black.
// ----------------------------------------------------------------------------
//  channel   direction  tdata / fields (lsb first)
//  s_axis    in         red[7:0] green[15:8] blue[23:16] column[32:24]
//                       row[41:33], zero pad [47:42]
//  m_axis    out        red[7:0] green[15:8] blue[23:16]
//  cfg       in         index 0 image_width, index 1 image_height, 10 bits
//
//  the result is presented on m_axis once it has passed the six register
//  stages; one pixel per clock sustained while m_axis_tready stays high.
//  each stage has its own valid bit and loads when empty or when the next
//  stage moves, so bubbles close up under an output stall.
//  synchronous active-low reset clears the valid bits and sets both
//  dimensions to 512.
// ----------------------------------------------------------------------------
module ycbcr_quadrant_blackout (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // red, green, blue, column, row, zero pad
    input  logic [47:0]                   s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // red, green, blue
    output logic [23:0]                   m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [ycq_pkg::DimWidth-1:0]  i_cfg_data
);
    import ycq_pkg::*;

    logic [DimWidth-1:0]   r_width, r_height;
    logic [NumStages-1:0]  r_valid;
    t_stage_en             w_en;

    logic [DimWidth-1:0]   w_width_sat, w_height_sat;
    logic [DimWidth-1:0]   w_half_w, w_half_h;
    logic [DimWidth-1:0]   w_col, w_row;
    logic                  w_blackout;
    logic [7:0]            w_ro, w_go, w_bo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= MaxDimension;
            r_height <= MaxDimension;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CfgImageWidth:  r_width  <= i_cfg_data;
                CfgImageHeight: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or its content moves on
    always_comb begin
        w_en[NumStages-1] = !r_valid[NumStages-1] || m_axis_tready;
        for (int k = NumStages - 2; k >= 0; k--) begin
            w_en[k] = !r_valid[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_en[0]) begin
                r_valid[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NumStages; k++) begin
                if (w_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // quadrant test against the saturated half dimensions
    assign w_width_sat  = (r_width > MaxDimension) ? MaxDimension : r_width;
    assign w_height_sat = (r_height > MaxDimension) ? MaxDimension : r_height;
    assign w_half_w     = w_width_sat >> 1;
    assign w_half_h     = w_height_sat >> 1;
    assign w_col        = {1'b0, s_axis_tdata[32:24]};
    assign w_row        = {1'b0, s_axis_tdata[41:33]};
    assign w_blackout   = ((w_col > w_half_w) && (w_row < w_half_h))
                       || ((w_col < w_half_w) && (w_row > w_half_h));

    ycq_convert u_convert (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_red      (s_axis_tdata[7:0]),
        .i_green    (s_axis_tdata[15:8]),
        .i_blue     (s_axis_tdata[23:16]),
        .i_blackout (w_blackout),
        .o_red      (w_ro),
        .o_green    (w_go),
        .o_blue     (w_bo)
    );

    assign s_axis_tready = w_en[0];
    assign m_axis_tvalid = r_valid[NumStages-1];
    assign m_axis_tdata  = {w_bo, w_go, w_ro};

endmodule

>>> hdl/ycq_convert.sv
// ----------------------------------------------------------------------------
// ycq_convert
// Six-stage datapath: RGB to YCbCr, optional blackout, YCbCr back to RGB.
// ----------------------------------------------------------------------------
module ycq_convert (
    input  logic                     i_clk,
    input  ycq_pkg::t_stage_en       i_en,
    input  logic [7:0]               i_red,
    input  logic [7:0]               i_green,
    input  logic [7:0]               i_blue,
    input  logic                     i_blackout,
    output logic [7:0]               o_red,
    output logic [7:0]               o_green,
    output logic [7:0]               o_blue
);
    import ycq_pkg::*;

    logic signed [8:0] w_r, w_g, w_b;

    // stage 1: forward products
    t_prod r_py_r, r_py_g, r_py_b;
    t_prod r_pcb_r, r_pcb_g, r_pcb_b;
    t_prod r_pcr_r, r_pcr_g, r_pcr_b;
    logic  r_black1;
    // stage 2: forward sums
    t_sum  r_sy, r_scb, r_scr;
    logic  r_black2;
    // stage 3: rounded YCbCr, chroma re-centered on zero
    logic [7:0]        r_y;
    logic signed [8:0] r_cb, r_cr;
    // stage 4: inverse products
    t_sum  r_py;
    t_prod r_pr_cr, r_pg_cb, r_pg_cr, r_pb_cb;
    // stage 5: inverse sums
    t_sum  r_sr, r_sg, r_sb;
    // stage 6: output register
    logic [7:0] r_ro, r_go, r_bo;

    logic [7:0]        n_y, n_cb8, n_cr8;
    logic signed [8:0] n_cb, n_cr;

    assign w_r = $signed({1'b0, i_red});
    assign w_g = $signed({1'b0, i_green});
    assign w_b = $signed({1'b0, i_blue});

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_py_r   <= w_r * KyR;
            r_py_g   <= w_g * KyG;
            r_py_b   <= w_b * KyB;
            r_pcb_r  <= w_r * KcbR;
            r_pcb_g  <= w_g * KcbG;
            r_pcb_b  <= w_b * KcbB;
            r_pcr_r  <= w_r * KcrR;
            r_pcr_g  <= w_g * KcrG;
            r_pcr_b  <= w_b * KcrB;
            r_black1 <= i_blackout;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_sy     <= t_sum'(r_py_r) + t_sum'(r_py_g) + t_sum'(r_py_b);
            r_scb    <= t_sum'(r_pcb_r) + t_sum'(r_pcb_g) + t_sum'(r_pcb_b);
            r_scr    <= t_sum'(r_pcr_r) + t_sum'(r_pcr_g) + t_sum'(r_pcr_b);
            r_black2 <= r_black1;
        end
    end

    always_comb begin
        n_y   = round_clamp(r_sy, NoOffset);
        n_cb8 = round_clamp(r_scb, ChromaZero);
        n_cr8 = round_clamp(r_scr, ChromaZero);
        n_cb  = $signed({1'b0, n_cb8}) - ChromaZero;
        n_cr  = $signed({1'b0, n_cr8}) - ChromaZero;
        if (r_black2) begin
            n_y  = BlackY;
            n_cb = 9'sd0;
            n_cr = 9'sd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_y  <= n_y;
            r_cb <= n_cb;
            r_cr <= n_cr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_py    <= $signed({4'd0, r_y, 16'd0});
            r_pr_cr <= r_cr * KrCr;
            r_pg_cb <= r_cb * KgCb;
            r_pg_cr <= r_cr * KgCr;
            r_pb_cb <= r_cb * KbCb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_sr <= r_py + t_sum'(r_pr_cr);
            r_sg <= r_py + t_sum'(r_pg_cb) + t_sum'(r_pg_cr);
            r_sb <= r_py + t_sum'(r_pb_cb);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_ro <= round_clamp(r_sr, NoOffset);
            r_go <= round_clamp(r_sg, NoOffset);
            r_bo <= round_clamp(r_sb, NoOffset);
        end
    end

    assign o_red   = r_ro;
    assign o_green = r_go;
    assign o_blue  = r_bo;

endmodule

>>> tb/sv/ycq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycq_checker
// Watches the pixel stream into and out of the quadrant blackout pipeline and
// keeps its own copy of the image dimensions. It predicts each output pixel
// and compares it with the next result that leaves the block.
// ----------------------------------------------------------------------------
module ycq_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_tvalid,
    input  logic                         i_in_tready,
    // red, green, blue, column, row, zero pad
    input  logic [47:0]                  i_in_tdata,
    input  logic                         i_out_tvalid,
    input  logic                         i_out_tready,
    // red, green, blue
    input  logic [23:0]                  i_out_tdata,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [ycq_pkg::DimWidth-1:0] i_cfg_data,
    output int                           o_errors,
    output int                           o_waiting,
    output int                           o_checked,
    output int                           o_blacked
);
    import ycq_pkg::*;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_rgb;

    // BT.601 matrices in 16.16 fixed point
    localparam int YfromR  = 19595;
    localparam int YfromG  = 38470;
    localparam int YfromB  = 7471;
    localparam int CbFromR = -11056;
    localparam int CbFromG = -21712;
    localparam int CbFromB = 32768;
    localparam int CrFromR = 32768;
    localparam int CrFromG = -27440;
    localparam int CrFromB = -5328;
    localparam int RfromCr = 91881;
    localparam int GfromCb = -22551;
    localparam int GfromCr = -46799;
    localparam int BfromCb = 116130;
    localparam int OneFx   = 65536;
    localparam int HalfFx  = 32768;
    localparam int ChromaMid = 128;
    localparam int DarkLuma  = 16;

    t_rgb                 expected_pixels[$];
    logic [DimWidth-1:0]  image_w;
    logic [DimWidth-1:0]  image_h;

    initial begin
        o_errors  = 0;
        o_waiting = 0;
        o_checked = 0;
        o_blacked = 0;
        image_w   = MaxDimension;
        image_h   = MaxDimension;
    end

    // nearest integer, halves go away from zero
    function automatic int round_away(input int s);
        if (s >= 0) begin
            return (s + HalfFx) >>> 16;
        end
        return -((-s + HalfFx) >>> 16);
    endfunction

    function automatic int sat_byte(input int v);
        if (v < 0) begin
            return 0;
        end
        if (v > 255) begin
            return 255;
        end
        return v;
    endfunction

    function automatic t_rgb convert_pixel(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b, input logic [8:0] col,
                                           input logic [8:0] row, output bit dark);
        t_rgb px;
        int   ri, gi, bi, luma, cb, cr, half_w, half_h;
        ri = r;
        gi = g;
        bi = b;
        half_w = ((image_w > MaxDimension) ? MaxDimension : image_w) >> 1;
        half_h = ((image_h > MaxDimension) ? MaxDimension : image_h) >> 1;
        luma = sat_byte(round_away(YfromR * ri + YfromG * gi + YfromB * bi));
        cb = sat_byte(round_away(CbFromR * ri + CbFromG * gi + CbFromB * bi) + ChromaMid);
        cr = sat_byte(round_away(CrFromR * ri + CrFromG * gi + CrFromB * bi) + ChromaMid);
        // top-right or bottom-left quadrant, pixels on the split lines are kept
        dark = ((int'(col) > half_w) && (int'(row) < half_h)) ||
               ((int'(col) < half_w) && (int'(row) > half_h));
        if (dark) begin
            luma = DarkLuma;
            cb   = ChromaMid;
            cr   = ChromaMid;
        end
        cb = cb - ChromaMid;
        cr = cr - ChromaMid;
        px.red   = 8'(sat_byte(round_away(luma * OneFx + RfromCr * cr)));
        px.green = 8'(sat_byte(round_away(luma * OneFx + GfromCb * cb + GfromCr * cr)));
        px.blue  = 8'(sat_byte(round_away(luma * OneFx + BfromCb * cb)));
        return px;
    endfunction

    always @(posedge i_clk) begin : watch
        t_rgb want;
        t_rgb got;
        bit   dark;
        if (!i_rst_n) begin
            expected_pixels.delete();
            image_w = MaxDimension;
            image_h = MaxDimension;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CfgImageWidth) begin
                    image_w = i_cfg_data;
                end else begin
                    image_h = i_cfg_data;
                end
            end
            if (i_out_tvalid && i_out_tready) begin
                got = i_out_tdata;
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected output transfer, expected none, got %h",
                             $time, got);
                    o_errors++;
                end else begin
                    want = expected_pixels.pop_front();
                    o_checked++;
                    if (got.red !== want.red) begin
                        $display("%0t: red mismatch, expected %0d, got %0d",
                                 $time, want.red, got.red);
                        o_errors++;
                    end
                    if (got.green !== want.green) begin
                        $display("%0t: green mismatch, expected %0d, got %0d",
                                 $time, want.green, got.green);
                        o_errors++;
                    end
                    if (got.blue !== want.blue) begin
                        $display("%0t: blue mismatch, expected %0d, got %0d",
                                 $time, want.blue, got.blue);
                        o_errors++;
                    end
                end
            end
            if (i_in_tvalid && i_in_tready) begin
                want = convert_pixel(i_in_tdata[7:0], i_in_tdata[15:8], i_in_tdata[23:16],
                                     i_in_tdata[32:24], i_in_tdata[41:33], dark);
                expected_pixels.push_back(want);
                if (dark) begin
                    o_blacked++;
                end
            end
        end
        o_waiting = expected_pixels.size();
    end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Pixel stream test of the quadrant blackout pipeline: directed colors and
// quadrant edges first, then random pixels under a range of image sizes,
// with random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb;
    import ycq_pkg::*;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    // red, green, blue, column, row, zero pad
    logic [47:0]         s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    // red, green, blue
    logic [23:0]         m_axis_tdata;
    logic                i_cfg_we;
    logic                i_cfg_index;
    logic [DimWidth-1:0] i_cfg_data;

    int          mismatches;
    int          waiting;
    int          checked;
    int          blacked;
    int unsigned cur_w;
    int unsigned cur_h;
    int          pixels_sent;
    int          settings_used;
    bit          tx_gaps;
    bit          hold_req;

    ycbcr_quadrant_blackout u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    ycq_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (s_axis_tvalid),
        .i_in_tready  (s_axis_tready),
        .i_in_tdata   (s_axis_tdata),
        .i_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .i_out_tdata  (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_errors     (mismatches),
        .o_waiting    (waiting),
        .o_checked    (checked),
        .o_blacked    (blacked)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("%0t: run did not finish in time", $time);
        $display("FAIL");
        $finish;
    end

    // mostly short idle stretches, now and then a long one
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 65) begin
            return 0;
        end else if (p < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 24);
    endfunction

    // output side: random stalls in busy stretches, plus one long hold-off
    initial begin
        int stall_left;
        int mode_left;
        bit busy_rx;
        m_axis_tready = 1'b0;
        stall_left = 0;
        mode_left = 0;
        busy_rx = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                stall_left = 80;
            end
            if (stall_left == 0) begin
                if (mode_left == 0) begin
                    busy_rx = ($urandom_range(0, 2) != 0);
                    mode_left = $urandom_range(20, 80);
                end
                mode_left--;
                if (busy_rx && ($urandom_range(0, 3) == 0)) begin
                    stall_left = pick_gap();
                end
            end
            if (stall_left > 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic [8:0] col, input logic [8:0] row);
        int gap;
        gap = tx_gaps ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {6'd0, row, col, b, g, r};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pixels_sent++;
    endtask

    // stop offering and let every pixel in flight come out
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (waiting != 0) @(negedge i_clk);
    endtask

    task automatic set_dims(input int unsigned w, input int unsigned h);
        drain();
        i_cfg_we    = 1'b1;
        i_cfg_index = CfgImageWidth;
        i_cfg_data  = DimWidth'(w);
        @(negedge i_clk);
        i_cfg_index = CfgImageHeight;
        i_cfg_data  = DimWidth'(h);
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        cur_w = w;
        cur_h = h;
        settings_used++;
    endtask

    function automatic logic [7:0] pick_channel();
        int p;
        p = $urandom_range(0, 7);
        if (p == 0) begin
            return 8'd0;
        end else if (p == 1) begin
            return 8'd255;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // lean toward the split line so both sides of the strict compare get hit
    function automatic logic [8:0] pick_coord(input int unsigned dim);
        int half;
        int c;
        half = ((dim > 512) ? 512 : dim) / 2;
        if ($urandom_range(0, 3) == 0) begin
            c = half + $urandom_range(0, 2) - 1;
            if (c < 0) begin
                c = 0;
            end else if (c > 511) begin
                c = 511;
            end
            return 9'(c);
        end
        return 9'($urandom_range(0, 511));
    endfunction

    task automatic send_random(input int n, input bit pressure);
        for (int i = 0; i < n; i++) begin
            if (!pressure && (i % 20 == 0)) begin
                tx_gaps = ($urandom_range(0, 3) != 0);
            end
            send_pixel(pick_channel(), pick_channel(), pick_channel(),
                       pick_coord(cur_w), pick_coord(cur_h));
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CfgImageWidth;
        i_cfg_data    = '0;
        cur_w         = 512;
        cur_h         = 512;
        pixels_sent   = 0;
        settings_used = 1;
        tx_gaps       = 1'b0;
        hold_req      = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset size 512 x 512, split at 256
        send_pixel(8'd0,   8'd0,   8'd0,   9'd0,   9'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 9'd0,   9'd0);
        send_pixel(8'd255, 8'd0,   8'd0,   9'd0,   9'd0);
        send_pixel(8'd0,   8'd255, 8'd0,   9'd0,   9'd0);
        send_pixel(8'd0,   8'd0,   8'd255, 9'd0,   9'd0);
        send_pixel(8'd255, 8'd255, 8'd0,   9'd511, 9'd511);
        send_pixel(8'd0,   8'd255, 8'd255, 9'd511, 9'd511);
        send_pixel(8'd255, 8'd0,   8'd255, 9'd256, 9'd256);
        send_pixel(8'd255, 8'd255, 8'd255, 9'd511, 9'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 9'd0,   9'd511);
        send_pixel(8'd200, 8'd50,  8'd10,  9'd257, 9'd255);
        send_pixel(8'd200, 8'd50,  8'd10,  9'd255, 9'd257);
        send_pixel(8'd200, 8'd50,  8'd10,  9'd256, 9'd0);
        send_pixel(8'd200, 8'd50,  8'd10,  9'd0,   9'd256);
        send_pixel(8'd200, 8'd50,  8'd10,  9'd511, 9'd256);
        send_pixel(8'd200, 8'd50,  8'd10,  9'd256, 9'd511);
        send_pixel(8'd128, 8'd128, 8'd128, 9'd255, 9'd255);
        send_pixel(8'd1,   8'd254, 8'd1,   9'd257, 9'd257);
        send_pixel(8'd170, 8'd85,  8'd170, 9'd340, 9'd85);
        send_pixel(8'd85,  8'd170, 8'd85,  9'd85,  9'd340);

        send_random(50, 1'b0);
        // zero size: half is zero, so no pixel is blacked out
        set_dims(0, 0);
        send_random(50, 1'b0);
        set_dims(1, 1);
        send_random(40, 1'b0);
        // output held off while the input keeps offering back to back
        set_dims(1023, 2);
        tx_gaps  = 1'b0;
        hold_req = 1'b1;
        send_random(60, 1'b1);
        set_dims(513, 700);
        send_random(50, 1'b0);
        set_dims(2, 3);
        send_random(40, 1'b0);
        set_dims(37, 100);
        send_random(60, 1'b0);
        set_dims(512, 1);
        send_random(40, 1'b0);
        for (int k = 0; k < 4; k++) begin
            set_dims($urandom_range(0, 1023), $urandom_range(0, 1023));
            send_random(50, 1'b0);
        end
        set_dims(1023, 1023);
        send_random(30, 1'b0);

        drain();
        repeat (4 * NumStages) @(posedge i_clk);
        $display("covered %0d pixels over %0d image sizes, %0d of them in blacked quadrants",
                 pixels_sent, settings_used, blacked);
        $display("%0d results checked, %0d mismatches, %0d still waiting",
                 checked, mismatches, waiting);
        if (mismatches == 0 && waiting == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/ycq_pkg.sv
hdl/ycq_convert.sv
hdl/ycbcr_quadrant_blackout.sv
tb/sv/ycq_checker.sv
tb/sv/tb.sv
